// ===== rtl/core/pmt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the program map section parser.
// Used by every module under rtl/core; the channel interfaces do not use it.
package pmt_pkg;

   localparam logic [7:0] TABLE_ID_PMT = 8'h02;
   localparam logic [7:0] SID_DESC_TAG = 8'h52;

   // Depth of the result queue between the parser and the output stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_BYTE  = 1'b1
   } command_type;

   typedef enum logic {
      KIND_ENTRY  = 1'b0,
      KIND_FINISH = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DONE      = 3'd1,
      ST_BAD_TABLE = 3'd2,
      ST_MISMATCH  = 3'd3,
      ST_TRUNCATED = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      PH_PCR_HI     = 4'd0,
      PH_PCR_LO     = 4'd1,
      PH_INFO_HI    = 4'd2,
      PH_INFO_LO    = 4'd3,
      PH_SKIP       = 4'd4,
      PH_ES_TYPE    = 4'd5,
      PH_ES_PID_HI  = 4'd6,
      PH_ES_PID_LO  = 4'd7,
      PH_ES_LEN_HI  = 4'd8,
      PH_ES_LEN_LO  = 4'd9,
      PH_DESC_TAG   = 4'd10,
      PH_DESC_LEN   = 4'd11,
      PH_DESC_FIRST = 4'd12,
      PH_DESC_BODY  = 4'd13
   } phase_type;

   // Everything one input item produces: an optional stream entry followed
   // by an optional finish result.
   typedef struct packed {
      logic        entry_v;
      logic        fin_v;
      logic [12:0] es_pid;
      logic [7:0]  stream_type;
      logic [7:0]  component_tag;
      logic        tag_valid;
      logic        is_section_type;
      logic [12:0] pcr_pid;
      status_type  status;
   } rec_type;

   function automatic logic is_section(input logic [7:0] st);
      return (st == 8'h05) || (st == 8'h06) || ((st >= 8'h0A) && (st <= 8'h0D));
   endfunction

endpackage

// ===== rtl/core/pmt_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
// The payload fields are plain logic vectors; pmt_pkg is not imported here.
interface pmt_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [7:0]  data_byte;
   logic        last_byte;
   logic [7:0]  table_id;
   logic [15:0] id_extension;
   logic        consolidated;

   modport source (output valid, command, data_byte, last_byte, table_id,
                   id_extension, consolidated, input ready);
   modport sink   (input valid, command, data_byte, last_byte, table_id,
                   id_extension, consolidated, output ready);
endinterface

interface pmt_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [12:0] es_pid;
   logic [7:0]  stream_type;
   logic [7:0]  component_tag;
   logic        tag_valid;
   logic        is_section_type;
   logic [12:0] pcr_pid;
   logic [2:0]  status;
   logic        last;

   modport source (output valid, kind, es_pid, stream_type, component_tag,
                   tag_valid, is_section_type, pcr_pid, status, last,
                   input ready);
   modport sink   (input valid, kind, es_pid, stream_type, component_tag,
                   tag_valid, is_section_type, pcr_pid, status, last,
                   output ready);
endinterface

// ===== rtl/core/pmt_section_parser.sv =====
`timescale 1ns / 1ps
// Top level of the program map section parser: front parser, result queue
// and output stage. Depends on pmt_pkg, pmt_ifs and the pmt_* modules.
//
// Usage: req_ch carries one beat per cycle, either a section start
// (command 0 with table_id, id_extension, consolidated) or one payload
// byte (command 1, last_byte on the final byte before the CRC). rsp_ch
// returns stream entries and a finish result; last marks the final result
// of the beat that caused it. csr_data sets the expected program number
// and is always accepted; write it only while the block is idle.
// Throughput: one request beat per cycle while the queue is not full. A
// beat that yields both an entry and a finish is sent as an entry beat and
// then a finish beat from the single output register. Results pass through
// the queue and then the output register. The four-record queue lets the
// parser keep taking beats while the receiver stalls; req_ch.ready drops
// only when the queue is full. Reset clears the parser state, the queue and
// the output register; the program number returns to zero.
module pmt_section_parser
   import pmt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pmt_req_if.sink     req_ch,
   pmt_rsp_if.source   rsp_ch,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   rec_type push_rec, head_rec;
   logic    push, full, pop, empty;

   pmt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_full    (full),
      .q_push    (push),
      .q_rec     (push_rec)
   );

   pmt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .full     (full),
      .pop      (pop),
      .head_rec (head_rec),
      .empty    (empty)
   );

   pmt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_rec (head_rec),
      .q_empty  (empty),
      .q_pop    (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== rtl/core/pmt_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts request beats, runs the section parser state and
// writes one result record per productive beat. Depends on pmt_pkg, pmt_ifs.
module pmt_front
   import pmt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   pmt_req_if.sink      req_ch,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data,
   input  logic         q_full,
   output logic         q_push,
   output rec_type      q_rec
);

   logic [15:0] program_number_ff, program_number_in;
   logic        done_ff, done_in;
   logic        active_ff, active_in;
   phase_type   phase_ff, phase_in;
   logic [11:0] skip_ff, skip_in;
   logic [11:0] info_ff, info_in;
   logic [7:0]  desc_ff, desc_in;
   logic        sid_ff, sid_in;
   logic [7:0]  type_ff, type_in;
   logic [12:0] pid_ff, pid_in;
   logic [7:0]  tag_ff, tag_in;
   logic        tv_ff, tv_in;
   logic [12:0] pcr_ff, pcr_in;
   logic        mismatch_ff, mismatch_in;

   logic        accept;
   logic        emit;
   logic [7:0]  b;
   logic [11:0] info_dec;

   assign csr_ready   = 1'b1;
   assign req_ch.ready = !q_full;
   assign accept = req_ch.valid && !q_full;
   assign b = req_ch.data_byte;
   assign info_dec = (info_ff != 12'd0) ? info_ff - 12'd1 : info_ff;

   always_comb begin
      program_number_in = csr_valid ? csr_data : program_number_ff;
      done_in     = done_ff;
      active_in   = active_ff;
      phase_in    = phase_ff;
      skip_in     = skip_ff;
      info_in     = info_ff;
      desc_in     = desc_ff;
      sid_in      = sid_ff;
      type_in     = type_ff;
      pid_in      = pid_ff;
      tag_in      = tag_ff;
      tv_in       = tv_ff;
      pcr_in      = pcr_ff;
      mismatch_in = mismatch_ff;
      emit        = 1'b0;
      q_rec       = '0;
      q_push      = 1'b0;

      if (accept) begin
         if (req_ch.command == CMD_START) begin
            active_in = 1'b0;
            if (done_ff) begin
               q_rec.fin_v  = 1'b1;
               q_rec.status = ST_DONE;
            end else if ((req_ch.table_id != TABLE_ID_PMT) || !req_ch.consolidated) begin
               q_rec.fin_v  = 1'b1;
               q_rec.status = ST_BAD_TABLE;
            end else begin
               active_in   = 1'b1;
               phase_in    = PH_PCR_HI;
               mismatch_in = (req_ch.id_extension != program_number_ff);
            end
         end else if (active_ff) begin
            case (phase_ff)
               PH_PCR_HI: begin
                  pcr_in   = {b[4:0], 8'h00};
                  phase_in = PH_PCR_LO;
               end
               PH_PCR_LO: begin
                  pcr_in   = {pcr_ff[12:8], b};
                  phase_in = PH_INFO_HI;
               end
               PH_INFO_HI: begin
                  skip_in  = {b[3:0], 8'h00};
                  phase_in = PH_INFO_LO;
               end
               PH_INFO_LO: begin
                  skip_in  = {skip_ff[11:8], b};
                  phase_in = (skip_in != 12'd0) ? PH_SKIP : PH_ES_TYPE;
               end
               PH_SKIP: begin
                  if (skip_ff != 12'd0) begin
                     skip_in = skip_ff - 12'd1;
                  end
                  if (skip_in == 12'd0) begin
                     phase_in = PH_ES_TYPE;
                  end
               end
               PH_ES_TYPE: begin
                  type_in  = b;
                  tag_in   = 8'h00;
                  tv_in    = 1'b0;
                  phase_in = PH_ES_PID_HI;
               end
               PH_ES_PID_HI: begin
                  pid_in   = {b[4:0], 8'h00};
                  phase_in = PH_ES_PID_LO;
               end
               PH_ES_PID_LO: begin
                  pid_in   = {pid_ff[12:8], b};
                  phase_in = PH_ES_LEN_HI;
               end
               PH_ES_LEN_HI: begin
                  info_in  = {b[3:0], 8'h00};
                  phase_in = PH_ES_LEN_LO;
               end
               PH_ES_LEN_LO: begin
                  info_in = {info_ff[11:8], b};
                  if (info_in == 12'd0) begin
                     emit     = 1'b1;
                     phase_in = PH_ES_TYPE;
                  end else begin
                     phase_in = PH_DESC_TAG;
                  end
               end
               PH_DESC_TAG: begin
                  sid_in   = (b == SID_DESC_TAG);
                  info_in  = info_dec;
                  phase_in = PH_DESC_LEN;
               end
               PH_DESC_LEN: begin
                  desc_in = b;
                  info_in = info_dec;
                  if (b == 8'h00) begin
                     emit     = (info_in == 12'd0);
                     phase_in = (info_in == 12'd0) ? PH_ES_TYPE : PH_DESC_TAG;
                  end else begin
                     phase_in = PH_DESC_FIRST;
                  end
               end
               PH_DESC_FIRST, PH_DESC_BODY: begin
                  if ((phase_ff == PH_DESC_FIRST) && sid_ff) begin
                     tag_in = b;
                     tv_in  = 1'b1;
                  end
                  info_in = info_dec;
                  if (desc_ff != 8'h00) begin
                     desc_in = desc_ff - 8'h01;
                  end
                  if (desc_in == 8'h00) begin
                     // A descriptor that overruns the ES info length still
                     // closes the entry once it is fully consumed.
                     emit     = (info_in == 12'd0);
                     phase_in = (info_in == 12'd0) ? PH_ES_TYPE : PH_DESC_TAG;
                  end else begin
                     phase_in = PH_DESC_BODY;
                  end
               end
               default: begin
               end
            endcase

            if (emit) begin
               q_rec.entry_v         = 1'b1;
               q_rec.es_pid          = pid_in;
               q_rec.stream_type     = type_in;
               q_rec.component_tag   = tv_in ? tag_in : 8'h00;
               q_rec.tag_valid       = tv_in;
               q_rec.is_section_type = is_section(type_in);
            end

            if (req_ch.last_byte) begin
               q_rec.fin_v = 1'b1;
               if ((phase_in == PH_SKIP) || (phase_in == PH_ES_TYPE)) begin
                  q_rec.status = mismatch_ff ? ST_MISMATCH : ST_OK;
               end else begin
                  q_rec.status = ST_TRUNCATED;
               end
               done_in   = 1'b1;
               active_in = 1'b0;
            end
         end
         q_rec.pcr_pid = pcr_in;
         q_push = q_rec.entry_v || q_rec.fin_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         program_number_ff <= '0;
         done_ff     <= 1'b0;
         active_ff   <= 1'b0;
         phase_ff    <= PH_PCR_HI;
         skip_ff     <= '0;
         info_ff     <= '0;
         desc_ff     <= '0;
         sid_ff      <= 1'b0;
         type_ff     <= '0;
         pid_ff      <= '0;
         tag_ff      <= '0;
         tv_ff       <= 1'b0;
         pcr_ff      <= '0;
         mismatch_ff <= 1'b0;
      end else begin
         program_number_ff <= program_number_in;
         done_ff     <= done_in;
         active_ff   <= active_in;
         phase_ff    <= phase_in;
         skip_ff     <= skip_in;
         info_ff     <= info_in;
         desc_ff     <= desc_in;
         sid_ff      <= sid_in;
         type_ff     <= type_in;
         pid_ff      <= pid_in;
         tag_ff      <= tag_in;
         tv_ff       <= tv_in;
         pcr_ff      <= pcr_in;
         mismatch_ff <= mismatch_in;
      end
   end

`ifndef SYNTH
   // Once a section has finished, no later start can reopen parsing.
   a_done_blocks_active: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && active_ff))
      else $error("parser active after a section was finished");

   // A finish result is always followed by the block being idle.
   a_finish_closes: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_rec.fin_v) |=> !active_ff)
      else $error("parser still active after a finish result");
`endif

endmodule

// ===== rtl/core/pmt_queue.sv =====
`timescale 1ns / 1ps
// Short result-record queue that decouples the parser from the output stage.
// Depends on pmt_pkg for the record type and queue depth.
module pmt_queue
   import pmt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   output logic    full,
   input  logic    pop,
   output rec_type head_rec,
   output logic    empty
);

   rec_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_rec = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into a full queue");
`endif

endmodule

// ===== rtl/core/pmt_back.sv =====
`timescale 1ns / 1ps
// Output stage: takes records from the queue and sends their entry and
// finish results as response beats. Depends on pmt_pkg and pmt_ifs.
module pmt_back
   import pmt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  rec_type head_rec,
   input  logic    q_empty,
   output logic    q_pop,
   pmt_rsp_if.source rsp_ch
);

   rec_type rec_ff, rec_in;
   logic    valid_ff, valid_in;
   logic    sent_ff, sent_in;
   logic    entry_now, final_beat, fire;

   assign entry_now  = rec_ff.entry_v && !sent_ff;
   assign final_beat = !(entry_now && rec_ff.fin_v);
   assign fire       = valid_ff && rsp_ch.ready;
   assign q_pop      = !q_empty && (!valid_ff || (fire && final_beat));

   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      sent_in  = sent_ff;
      if (!valid_ff || (fire && final_beat)) begin
         rec_in   = head_rec;
         valid_in = q_pop;
         sent_in  = 1'b0;
      end else if (fire) begin
         sent_in = 1'b1;
      end
   end

   assign rsp_ch.valid           = valid_ff;
   assign rsp_ch.kind            = entry_now ? KIND_ENTRY : KIND_FINISH;
   assign rsp_ch.es_pid          = entry_now ? rec_ff.es_pid : '0;
   assign rsp_ch.stream_type     = entry_now ? rec_ff.stream_type : '0;
   assign rsp_ch.component_tag   = entry_now ? rec_ff.component_tag : '0;
   assign rsp_ch.tag_valid       = entry_now && rec_ff.tag_valid;
   assign rsp_ch.is_section_type = entry_now && rec_ff.is_section_type;
   assign rsp_ch.pcr_pid         = rec_ff.pcr_pid;
   assign rsp_ch.status          = entry_now ? ST_OK : rec_ff.status;
   assign rsp_ch.last            = final_beat;

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sent_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sent_ff  <= sent_in;
      end
   end

`ifndef SYNTH
   // The entry beat of a record is only marked sent when a finish follows.
   a_sent_has_finish: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && sent_ff) |-> rec_ff.fin_v)
      else $error("second beat of a record without a finish result");
`endif

endmodule
